/* hdl/fqrs_pkg.sv */
// Package for the FIFO queue with reverse and search.
// Holds the action and status codes and the fixed port widths.
// No dependencies.
package fqrs_pkg;

    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int OCC_W  = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_REVERSE = 2'd2,
        ACT_SEARCH  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

/* hdl/fifo_queue_reverse_search_core.sv */
// FIFO queue of signed values with in-place reversal and search; needs fqrs_pkg.
// Push, pop and reverse go from the input transfer to S_EMIT, which loads the registered result;
// a search goes through S_SEARCH, comparing entries from the head until a match or the last entry.
// One item at a time: o_stall is high outside S_IDLE, and S_EMIT holds the result while the
// output stalls; one memory read per cycle.
// Reset (synchronous, active low) empties the queue; entry memory is not cleared.
module fifo_queue_reverse_search_core
    import fqrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [ACT_W-1:0]         i_action,
    input  logic signed [DATA_W-1:0] i_value,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [POS_W-1:0]         o_position,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic                     o_is_empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X   = (CW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

    // physical slot of logical position p from head h
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                              input logic [CW-1:0] p,
                                              input logic          rev);
        logic [CW:0] hx;
        logic [CW:0] px;
        logic [CW:0] s;
        hx = (CW+1)'(h);
        px = (CW+1)'(p);
        if (!rev) begin
            s = hx + px;
            if (s >= DEPTH_X) begin
                s = s - DEPTH_X;
            end
        end else if (hx >= px) begin
            s = hx - px;
        end else begin
            s = hx + DEPTH_X - px;
        end
        return s[AW-1:0];
    endfunction

    // neighbor slot one logical step toward the tail
    function automatic logic [AW-1:0] step(input logic [AW-1:0] s, input logic rev);
        logic [AW-1:0] r;
        if (rev) begin
            r = (s == '0) ? LAST_SLOT : s - AW'(1);
        end else begin
            r = (s == LAST_SLOT) ? '0 : s + AW'(1);
        end
        return r;
    endfunction

    // entry memory
    logic [VALUE_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    // control and result registers
    t_state                 r_state;
    logic [AW-1:0]          r_head;
    logic [CW-1:0]          r_count;
    logic                   r_rev;
    logic [AW-1:0]          r_slot;
    logic [CW-1:0]          r_cmp_pos;
    logic [VALUE_WIDTH-1:0] r_value;
    t_status                r_res_status;
    logic [CW-1:0]          r_res_pos;
    logic                   r_res_pop;

    // combinational control
    logic                   accept;
    t_action                act;
    logic [VALUE_WIDTH-1:0] v_ext;
    logic                   is_full;
    logic                   is_empty_q;
    logic                   hit;
    logic                   last;
    logic                   search_more;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic                   out_free;

    always_comb begin
        accept      = i_valid && (r_state == S_IDLE);
        act         = t_action'(i_action);
        v_ext       = VALUE_WIDTH'(i_value);
        is_full     = (r_count == DEPTH_C);
        is_empty_q  = (r_count == '0);
        hit         = (r_rd_data == r_value);
        last        = ((r_cmp_pos + CW'(1)) == r_count);
        search_more = (r_state == S_SEARCH) && !hit && !last;
        out_free    = !o_valid || !i_stall;

        // push writes at the tail
        mem_we    = accept && (act == ACT_PUSH) && !is_full;
        mem_waddr = slot_of(r_head, r_count, r_rev);

        // pop and search start at the head; search then walks toward the tail
        mem_re    = (accept && (act == ACT_POP || act == ACT_SEARCH) && !is_empty_q)
                    || search_more;
        mem_raddr = (r_state == S_SEARCH) ? r_slot : r_head;
    end

    assign o_stall = (r_state != S_IDLE);

    // memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= v_ext;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // state machine and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // drop valid after a result transfer unless a new result loads now
            if (o_valid && !i_stall && (r_state != S_EMIT)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_value      <= v_ext;
                        r_res_status <= ST_OK;
                        r_res_pos    <= '0;
                        r_res_pop    <= 1'b0;
                        r_state      <= S_EMIT;
                        unique case (act)
                            ACT_PUSH: begin
                                if (is_full) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ACT_POP: begin
                                if (is_empty_q) begin
                                    r_res_status <= ST_EMPTY;
                                end else begin
                                    r_res_pop <= 1'b1;
                                    r_head    <= step(r_head, r_rev);
                                    r_count   <= r_count - CW'(1);
                                end
                            end
                            ACT_REVERSE: begin
                                if (!is_empty_q) begin
                                    r_head <= slot_of(r_head, r_count - CW'(1), r_rev);
                                    r_rev  <= !r_rev;
                                end
                            end
                            ACT_SEARCH: begin
                                if (is_empty_q) begin
                                    r_res_status <= ST_NOT_FOUND;
                                end else begin
                                    r_slot    <= step(r_head, r_rev);
                                    r_cmp_pos <= '0;
                                    r_state   <= S_SEARCH;
                                end
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    // compare the entry read last cycle, read the next one
                    if (hit) begin
                        r_res_status <= ST_OK;
                        r_res_pos    <= r_cmp_pos;
                        r_state      <= S_EMIT;
                    end else if (last) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_EMIT;
                    end else begin
                        r_slot    <= step(r_slot, r_rev);
                        r_cmp_pos <= r_cmp_pos + CW'(1);
                    end
                end
                S_EMIT: begin
                    // result transfer waits for a free output register
                    if (out_free) begin
                        o_valid     <= 1'b1;
                        o_status    <= r_res_status;
                        o_data      <= r_res_pop ? DATA_W'(r_rd_data) : '0;
                        o_position  <= POS_W'(r_res_pos);
                        o_occupancy <= OCC_W'(r_count);
                        o_is_empty  <= is_empty_q;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
